// ----- design/hpfd_pkg.sv -----
// Shared types, constants and control structs for the heartbeat phi failure detector.
// No dependencies; every other file in the design imports this package.
package hpfd_pkg;

  localparam int PEERS_DEF        = 16;
  localparam int WINDOW_DEPTH_DEF = 64;

  localparam int TIME_W  = 48;
  localparam int GAP_W   = 32;
  localparam int PHI_W   = 24;
  localparam int THR_W   = 16;
  localparam int SCALE_W = 16;
  localparam int PROD_W  = PHI_W + SCALE_W;
  localparam int DIV_STEPS = PHI_W;
  localparam int STEP_W  = 5;

  localparam logic [PHI_W-1:0] PHI_MAX = '1;

  localparam logic [1:0] ACT_REPORT    = 2'd0;
  localparam logic [1:0] ACT_INTERPRET = 2'd1;
  localparam logic [1:0] ACT_REMOVE    = 2'd2;
  localparam logic [1:0] ACT_FORCE     = 2'd3;

  localparam logic [1:0] CFG_MAX_INTERVAL  = 2'd0;
  localparam logic [1:0] CFG_INIT_INTERVAL = 2'd1;
  localparam logic [1:0] CFG_THRESHOLD     = 2'd2;
  localparam logic [1:0] CFG_PHI_SCALE     = 2'd3;

  localparam logic [GAP_W-1:0]   MAX_INTERVAL_RST  = 32'd2000000;
  localparam logic [GAP_W-1:0]   INIT_INTERVAL_RST = 32'd2000000;
  localparam logic [THR_W-1:0]   THRESHOLD_RST     = 16'd2048;
  localparam logic [SCALE_W-1:0] PHI_SCALE_RST     = 16'd28462;

  typedef struct packed {
    logic [1:0]        action;
    logic [3:0]        peer;
    logic [TIME_W-1:0] now_time;
  } in_t;

  typedef struct packed {
    logic             known;
    logic             convicted;
    logic [PHI_W-1:0] phi_value;
  } out_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic div_step;
    logic mul;
    logic cmp;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       in_range;
    logic       known;
    logic       need_div;
  } status_t;

endpackage

// ----- design/hpfd_dp.sv -----
// Datapath: config registers, peer table, sample memory, phi divider and scaling.
// Depends on hpfd_pkg; sequenced by hpfd_ctrl through cmd_t / status_t.
module hpfd_dp #(
  parameter int PEERS        = hpfd_pkg::PEERS_DEF,
  parameter int WINDOW_DEPTH = hpfd_pkg::WINDOW_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  hpfd_pkg::in_t     in_data,
  input  logic              cfg_valid,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  hpfd_pkg::cmd_t    cmd,
  output hpfd_pkg::status_t status,
  output hpfd_pkg::out_t    out_data
);
  import hpfd_pkg::*;

  localparam int PIDX_W = (PEERS > 1) ? $clog2(PEERS) : 1;
  localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W  = GAP_W + $clog2(WINDOW_DEPTH);
  localparam int NUM_W  = TIME_W + CNT_W;
  localparam int SMP_N  = PEERS * WINDOW_DEPTH;
  localparam int SA_W   = (SMP_N > 1) ? $clog2(SMP_N) : 1;

  typedef struct packed {
    logic [TIME_W-1:0] last;
    logic [CNT_W-1:0]  count;
    logic [SLOT_W-1:0] slot;
    logic [SUM_W-1:0]  sum;
  } rec_t;

  logic [GAP_W-1:0]   gap_limit, initial_interval;
  logic [THR_W-1:0]   convict_threshold;
  logic [SCALE_W-1:0] phi_scale;

  logic [PEERS-1:0] peer_valid;
  rec_t             rec_mem [PEERS];
  logic [GAP_W-1:0] smp_mem [SMP_N];
  rec_t             rec_rd;
  logic [GAP_W-1:0] smp_rd;

  logic [1:0]        act;
  logic [PIDX_W-1:0] peer;
  logic [TIME_W-1:0] now;
  logic              in_range, known;

  logic [TIME_W-1:0] el;
  logic [NUM_W-1:0]  num;
  logic [SUM_W-1:0]  rem;
  logic [PHI_W-1:0]  dsh;
  logic [PHI_W-1:0]  phi;
  logic [PROD_W-1:0] prod;
  logic              conv;

  logic [TIME_W-1:0] el_c;
  logic [SA_W-1:0]   smp_raddr, smp_waddr;
  logic              full;
  logic [SLOT_W-1:0] slot_inc, slot_zero_inc;
  logic [SUM_W:0]    trial;
  logic              is_rep, is_int;
  rec_t              rec_new;

  always_comb begin
    el_c = (now >= rec_rd.last) ? now - rec_rd.last : '0;
    smp_raddr = SA_W'(int'(peer) * WINDOW_DEPTH + int'(rec_rd.slot));
    smp_waddr = known ? smp_raddr : SA_W'(int'(peer) * WINDOW_DEPTH);
    full = rec_rd.count >= CNT_W'(WINDOW_DEPTH);
    slot_inc = (int'(rec_rd.slot) == WINDOW_DEPTH - 1) ? '0 : rec_rd.slot + 1'b1;
    slot_zero_inc = (WINDOW_DEPTH == 1) ? '0 : SLOT_W'(1);
    trial = {rem, dsh[PHI_W-1]};
    is_rep = cmd.exec && in_range && act == ACT_REPORT;
    is_int = cmd.exec && in_range && act == ACT_INTERPRET && known;
    rec_new = rec_rd;
    rec_new.last = now;
    if (!known) begin
      rec_new.count = CNT_W'(1);
      rec_new.slot  = slot_zero_inc;
      rec_new.sum   = SUM_W'(initial_interval);
    end else if (el <= TIME_W'(gap_limit)) begin
      rec_new.count = full ? rec_rd.count : rec_rd.count + 1'b1;
      rec_new.slot  = slot_inc;
      rec_new.sum   = rec_rd.sum - (full ? SUM_W'(smp_rd) : '0) + SUM_W'(el[GAP_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_limit         <= MAX_INTERVAL_RST;
      initial_interval  <= INIT_INTERVAL_RST;
      convict_threshold <= THRESHOLD_RST;
      phi_scale         <= PHI_SCALE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MAX_INTERVAL:  gap_limit         <= cfg_data;
        CFG_INIT_INTERVAL: initial_interval  <= cfg_data;
        CFG_THRESHOLD:     convict_threshold <= cfg_data[THR_W-1:0];
        CFG_PHI_SCALE:     phi_scale         <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peer_valid <= '0;
    end else if (is_rep) begin
      peer_valid[peer] <= 1'b1;
    end else if (cmd.exec && in_range && act == ACT_REMOVE) begin
      peer_valid[peer] <= 1'b0;
    end
  end

  // peer table and sample window, registered reads at the latched peer
  always_ff @(posedge clk) begin
    rec_rd <= rec_mem[peer];
    smp_rd <= smp_mem[smp_raddr];
    if (is_rep) begin
      rec_mem[peer] <= rec_new;
      if (!known || el <= TIME_W'(gap_limit)) begin
        smp_mem[smp_waddr] <= known ? el[GAP_W-1:0] : initial_interval;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act      <= in_data.action;
      peer     <= PIDX_W'(in_data.peer);
      now      <= in_data.now_time;
      in_range <= 32'(in_data.peer) < PEERS;
      known    <= (32'(in_data.peer) < PEERS) && peer_valid[PIDX_W'(in_data.peer)];
    end
    el  <= el_c;
    num <= NUM_W'(el_c) * NUM_W'(rec_rd.count);
    if (cmd.exec) begin
      rem <= SUM_W'(num >> 16);
      dsh <= {num[15:0], 8'd0};
      if (in_range && act == ACT_FORCE) begin
        phi  <= PHI_W'(convict_threshold);
        conv <= 1'b1;
      end else if (is_int && rec_rd.sum == '0) begin
        phi  <= (el != '0) ? PHI_MAX : '0;
        conv <= 1'b0;
      end else if (is_int && num >= (NUM_W'(rec_rd.sum) << 16)) begin
        phi  <= PHI_MAX;
        conv <= 1'b0;
      end else begin
        phi  <= '0;
        conv <= 1'b0;
      end
    end
    // restoring division, one quotient bit a step
    if (cmd.div_step) begin
      dsh <= dsh << 1;
      if (trial >= {1'b0, rec_rd.sum}) begin
        rem <= SUM_W'(trial - {1'b0, rec_rd.sum});
        phi <= {phi[PHI_W-2:0], 1'b1};
      end else begin
        rem <= trial[SUM_W-1:0];
        phi <= {phi[PHI_W-2:0], 1'b0};
      end
    end
    if (cmd.mul) begin
      prod <= PROD_W'(phi_scale) * PROD_W'(phi);
    end
    if (cmd.cmp) begin
      conv <= prod > PROD_W'({convict_threshold, 16'd0});
    end
    if (cmd.out_load) begin
      out_data.known     <= known;
      out_data.convicted <= conv;
      out_data.phi_value <= phi;
    end
  end

  assign status.action   = act;
  assign status.in_range = in_range;
  assign status.known    = known;
  assign status.need_div = rec_rd.sum != '0 && num < (NUM_W'(rec_rd.sum) << 16);

endmodule

// ----- design/hpfd_ctrl.sv -----
// Controller state machine: sequences read, execute, divide, scale and output beats.
// Depends on hpfd_pkg; drives hpfd_dp through cmd_t.
module hpfd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  hpfd_pkg::status_t status,
  output hpfd_pkg::cmd_t    cmd
);
  import hpfd_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD1  = 3'd1;
  localparam logic [2:0] S_RD2  = 3'd2;
  localparam logic [2:0] S_EXEC = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_MUL  = 3'd5;
  localparam logic [2:0] S_CMP  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]        state, state_next;
  logic [STEP_W-1:0] step, step_next;
  logic              out_valid_next;
  logic              interp;

  assign in_ready = state == S_IDLE;
  assign interp = status.in_range && status.known && status.action == ACT_INTERPRET;

  always_comb begin
    state_next     = state;
    step_next      = step;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_RD1;
        end
      end
      S_RD1: state_next = S_RD2;
      S_RD2: state_next = S_EXEC;
      S_EXEC: begin
        cmd.exec  = 1'b1;
        step_next = '0;
        if (interp) begin
          state_next = status.need_div ? S_DIV : S_MUL;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_next    = step + 1'b1;
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        cmd.cmp    = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ----- design/heartbeat_phi_failure_detector_core.sv -----
// Channel  Signals                                   Beat
// in       in_valid / in_ready / in_data (in_t)      action, peer, now_time
// out      out_valid / out_ready / out_data (out_t)  known, convicted, phi_value
// cfg      cfg_valid / cfg_ready / cfg_index, cfg_data  register write, always ready
//
// An interpret of a known peer that needs the divider goes from accept through the table
// and window reads, execute, the one-bit-a-step divider, scaling and the output load. An
// interpret of a known peer with a zero mean or a saturated phi skips the divider but
// still scales; every other beat skips both. One beat is in flight at a time; in_ready
// returns the cycle after the output register loads, and the next is taken while a
// result still sits there. A stalled output holds the controller until it drains. Reset
// clears the peer valid bits and config registers; window memories need no clearing pass.
// Depends on hpfd_pkg, hpfd_ctrl and hpfd_dp.
module heartbeat_phi_failure_detector_core #(
  parameter int PEERS        = hpfd_pkg::PEERS_DEF,
  parameter int WINDOW_DEPTH = hpfd_pkg::WINDOW_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  hpfd_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output hpfd_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [1:0]     cfg_index,
  input  logic [31:0]    cfg_data
);
  import hpfd_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  hpfd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  hpfd_dp #(
    .PEERS        (PEERS),
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule

// ----- verif/tb.sv -----
// Self-checking bench for heartbeat_phi_failure_detector_core: directed table, then
// random heartbeat traffic over several register settings, checked against a local model.
// Depends on hpfd_pkg and the design sources.
module tb;
  import hpfd_pkg::*;

  localparam int NPEER = 16;
  localparam int DEPTH = 64;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE = 40;

  typedef struct {
    logic [1:0]        act;
    logic [3:0]        peer;
    logic [TIME_W-1:0] t;
    bit                typed;
    out_t              res;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_MAX_INTERVAL;
  logic [31:0] cfg_data = '0;

  // typed expectation travelling with the current beat
  bit   row_typed = 1'b0;
  out_t row_res = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fails = 0;
  int quiet = 0;

  // local copy of detector state and registers
  logic [GAP_W-1:0]   m_max_iv, m_init_iv;
  logic [THR_W-1:0]   m_thr;
  logic [SCALE_W-1:0] m_scale;
  bit                 hb_valid [NPEER];
  logic [TIME_W-1:0]  hb_last  [NPEER];
  logic [GAP_W-1:0]   hb_gaps  [NPEER][DEPTH];
  int                 hb_count [NPEER];
  int                 hb_slot  [NPEER];
  logic [63:0]        hb_sum   [NPEER];

  out_t pending_results[$];

  heartbeat_phi_failure_detector_core dut (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic void forget_peer(int p);
    hb_valid[p] = 1'b0;
    hb_last[p]  = '0;
    hb_count[p] = 0;
    hb_slot[p]  = 0;
    hb_sum[p]   = '0;
    for (int i = 0; i < DEPTH; i++) hb_gaps[p][i] = '0;
  endfunction

  function automatic void push_gap(int p, logic [GAP_W-1:0] g);
    if (hb_count[p] >= DEPTH) begin
      hb_sum[p] -= 64'(hb_gaps[p][hb_slot[p]]);
    end else begin
      hb_count[p]++;
    end
    hb_gaps[p][hb_slot[p]] = g;
    hb_sum[p] += 64'(g);
    hb_slot[p] = (hb_slot[p] + 1) % DEPTH;
  endfunction

  function automatic logic [63:0] since_last(int p, logic [TIME_W-1:0] now);
    return (now >= hb_last[p]) ? 64'(now - hb_last[p]) : 64'd0;
  endfunction

  function automatic logic [PHI_W-1:0] phi_of(int p, logic [TIME_W-1:0] now);
    logic [63:0] el, num, q0, r;
    el = since_last(p, now);
    if (hb_sum[p] == 0) return (el > 0) ? PHI_MAX : '0;
    num = el * 64'(hb_count[p]);
    if (num >= (hb_sum[p] << 16)) return PHI_MAX;
    q0 = num / hb_sum[p];
    r  = num % hb_sum[p];
    return PHI_W'((q0 << 8) + ((r << 8) / hb_sum[p]));
  endfunction

  function automatic out_t detector_step(in_t x);
    out_t o;
    int p;
    logic [63:0] g;
    o = '0;
    p = int'(x.peer);
    o.known = hb_valid[p];
    case (x.action)
      ACT_REPORT: begin
        if (!hb_valid[p]) begin
          forget_peer(p);
          push_gap(p, m_init_iv);
          hb_valid[p] = 1'b1;
        end else begin
          g = since_last(p, x.now_time);
          if (g <= 64'(m_max_iv)) push_gap(p, GAP_W'(g));
        end
        hb_last[p] = x.now_time;
      end
      ACT_INTERPRET: begin
        if (hb_valid[p]) begin
          o.phi_value = phi_of(p, x.now_time);
          o.convicted = (64'(m_scale) * 64'(o.phi_value)) > (64'(m_thr) << 16);
        end
      end
      ACT_REMOVE: forget_peer(p);
      default: begin
        o.convicted = 1'b1;
        o.phi_value = PHI_W'(m_thr);
      end
    endcase
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    fails++;
  endtask

  // accept monitor, result checker and watchdog
  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      m_max_iv  <= MAX_INTERVAL_RST;
      m_init_iv <= INIT_INTERVAL_RST;
      m_thr     <= THRESHOLD_RST;
      m_scale   <= PHI_SCALE_RST;
      for (int p = 0; p < NPEER; p++) forget_peer(p);
      quiet <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MAX_INTERVAL:  m_max_iv  <= cfg_data;
          CFG_INIT_INTERVAL: m_init_iv <= cfg_data;
          CFG_THRESHOLD:     m_thr     <= cfg_data[THR_W-1:0];
          default:           m_scale   <= cfg_data[SCALE_W-1:0];
        endcase
      end
      if (in_valid && in_ready) begin
        want = detector_step(in_data);
        pending_results.insert(pending_results.size(), row_typed ? row_res : want);
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected beat", 32'(out_data.phi_value), 32'd0);
        end else begin
          want = pending_results.pop_front();
          if (out_data.known !== want.known)
            report_mismatch("known", 32'(out_data.known), 32'(want.known));
          if (out_data.convicted !== want.convicted)
            report_mismatch("convicted", 32'(out_data.convicted), 32'(want.convicted));
          if (out_data.phi_value !== want.phi_value)
            report_mismatch("phi_value", 32'(out_data.phi_value), 32'(want.phi_value));
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet <= 0;
      else
        quiet <= quiet + 1;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_beat(in_t x, bit typed, out_t res);
    int n;
    n = 0;
    while ($urandom_range(99) < send_idle_pct) n++;
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_data   <= x;
    row_typed <= typed;
    row_res   <= res;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_regs(logic [31:0] mx, logic [31:0] iv, logic [31:0] th, logic [31:0] sc);
    logic [31:0] v [4];
    v = '{mx, iv, th, sc};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data  <= v[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  row_t dir_rows [20];
  logic [31:0] ph_max  [6] = '{32'd2000000, 32'd5000, 32'd0, 32'hFFFF_FFFF, 32'd3000, 32'd2000000};
  logic [31:0] ph_init [6] = '{32'd2000000, 32'd1000, 32'd1, 32'hFFFF_FFFF, 32'd1500, 32'd2000000};
  logic [31:0] ph_thr  [6] = '{32'd2048, 32'd2048, 32'd0, 32'hFFFF, 32'd512, 32'd2048};
  logic [31:0] ph_scale[6] = '{32'd28462, 32'd28462, 32'hFFFF, 32'd0, 32'd40000, 32'd28462};
  int          ph_gap  [6] = '{1000000, 1000, 1000, 4000, 1500, 1000000};

  initial begin
    in_t x;
    out_t none;
    logic [TIME_W-1:0] now;
    int r;
    none = '0;
    dir_rows = '{
      '{ACT_REPORT,    4'd0,  48'd0,          1, '{1'b0, 1'b0, 24'd0}},
      '{ACT_INTERPRET, 4'd0,  48'd0,          1, '{1'b1, 1'b0, 24'd0}},
      '{ACT_INTERPRET, 4'd1,  48'd100,        1, '{1'b0, 1'b0, 24'd0}},
      '{ACT_FORCE,     4'd1,  48'd100,        1, '{1'b0, 1'b1, 24'd2048}},
      '{ACT_REPORT,    4'd0,  48'd1000000,    0, '{1'b0, 1'b0, 24'd0}},
      '{ACT_INTERPRET, 4'd0,  48'd3000000,    0, '{1'b0, 1'b0, 24'd0}},
      '{ACT_REPORT,    4'd0,  48'd6000000,    0, '{1'b0, 1'b0, 24'd0}},
      '{ACT_INTERPRET, 4'd0,  48'd6000000,    1, '{1'b1, 1'b0, 24'd0}},
      '{ACT_REMOVE,    4'd0,  48'd6000000,    1, '{1'b1, 1'b0, 24'd0}},
      '{ACT_INTERPRET, 4'd0,  48'd6000000,    1, '{1'b0, 1'b0, 24'd0}},
      '{ACT_REMOVE,    4'd5,  48'd6000000,    1, '{1'b0, 1'b0, 24'd0}},
      '{ACT_FORCE,     4'd5,  48'd6000000,    1, '{1'b0, 1'b1, 24'd2048}},
      '{ACT_REPORT,    4'd15, 48'hFFFF_FFFF_FFFF, 1, '{1'b0, 1'b0, 24'd0}},
      '{ACT_REPORT,    4'd15, 48'd0,          1, '{1'b1, 1'b0, 24'd0}},
      '{ACT_INTERPRET, 4'd15, 48'd0,          0, '{1'b0, 1'b0, 24'd0}},
      '{ACT_INTERPRET, 4'd15, 48'hFFFF_FFFF_FFFF, 1, '{1'b1, 1'b1, 24'hFF_FFFF}},
      '{ACT_REPORT,    4'd7,  48'd500,        0, '{1'b0, 1'b0, 24'd0}},
      '{ACT_REPORT,    4'd7,  48'd1500,       0, '{1'b0, 1'b0, 24'd0}},
      '{ACT_INTERPRET, 4'd7,  48'd2000000,    0, '{1'b0, 1'b0, 24'd0}},
      '{ACT_FORCE,     4'd7,  48'd2000000,    1, '{1'b1, 1'b1, 24'd2048}}
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 35;
    recv_idle_pct = 80;
    foreach (dir_rows[i]) begin
      x = '{dir_rows[i].act, dir_rows[i].peer, dir_rows[i].t};
      send_beat(x, dir_rows[i].typed, dir_rows[i].res);
    end
    // zero mean: flush the seed out with zero gaps, then interpret at and after last beat
    for (int i = 0; i < DEPTH + 1; i++) send_beat('{ACT_REPORT, 4'd3, 48'd100}, 0, none);
    send_beat('{ACT_INTERPRET, 4'd3, 48'd100}, 0, none);
    send_beat('{ACT_INTERPRET, 4'd3, 48'd101}, 0, none);
    // hold until every result is home
    drain();

    now = 48'd10000000;
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) write_regs(ph_max[ph], ph_init[ph], ph_thr[ph], ph_scale[ph]);
      send_idle_pct = (ph < 2) ? 35 : (ph < 4) ? 80 : 0;
      recv_idle_pct = (ph < 2) ? 80 : (ph < 4) ? 35 : 0;
      if (ph == 4) now = {16'hFFFF, 32'h0} | 48'($urandom);
      if (ph == 5) now = 48'($urandom_range(1000));
      for (int n = 0; n < 250; n++) begin
        r = $urandom_range(99);
        if (r < 5)       now = now - 48'($urandom_range(ph_gap[ph]));
        else if (r < 10) now = now + 48'($urandom);
        else if (r < 90) now = now + 48'($urandom_range(2 * ph_gap[ph]));
        x.now_time = now;
        x.peer = ($urandom_range(99) < 70) ? 4'($urandom_range(1)) : 4'($urandom);
        r = $urandom_range(99);
        if (r < 50)      x.action = ACT_REPORT;
        else if (r < 85) x.action = ACT_INTERPRET;
        else if (r < 90) x.action = ACT_REMOVE;
        else             x.action = ACT_FORCE;
        // keep the busy peers' windows growing so eviction is reached
        if (x.action == ACT_REMOVE && x.peer < 2) x.action = ACT_INTERPRET;
        send_beat(x, 0, none);
      end
      drain();
    end

    if (fails == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
